// ===== rtl/core/epc2d_pkg.sv =====
`default_nettype none

package epc2d_pkg;

  // Port widths.
  localparam int VEL_W   = 32;
  localparam int MASS_W  = 31;

  // Internal widths. Differences of two 32-bit values need 33 bits.
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 33;
  localparam int PROD_W  = 66;
  localparam int INNER_W = 67;
  localparam int N2_W    = 66;
  localparam int HALF_W  = 33;
  localparam int NUM1_W  = 99;
  // The projected velocity never exceeds |va - vb|, which is below 2^33.
  localparam int Q1_W    = 33;
  localparam int R1_W    = 66;
  localparam int K_W     = 32;
  localparam int NUM2_W  = 65;
  // The mass-weighted correction is at most twice the projection.
  localparam int Q2_W    = 34;
  localparam int R2_W    = 32;
  localparam int MSUM_W  = 32;
  localparam int COR_W   = 36;

  typedef struct packed {
    logic signed [VEL_W-1:0] va_x;
    logic signed [VEL_W-1:0] va_y;
    logic signed [VEL_W-1:0] vb_x;
    logic signed [VEL_W-1:0] vb_y;
    logic [MASS_W-1:0]       ma;
    logic [MASS_W-1:0]       mb;
  } ctx_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    ctx_t                     ctx;
  } s1_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] pix;
    logic signed [PROD_W-1:0] piy;
    logic signed [PROD_W-1:0] pnx;
    logic signed [PROD_W-1:0] pny;
    logic [MAG_W-1:0]         dmag_x;
    logic [MAG_W-1:0]         dmag_y;
    logic                     dsg_x;
    logic                     dsg_y;
    ctx_t                     ctx;
  } s2_t;

  typedef struct packed {
    logic [N2_W-1:0]  imag;
    logic             isg;
    logic [N2_W-1:0]  n2;
    logic [MAG_W-1:0] dmag_x;
    logic [MAG_W-1:0] dmag_y;
    logic             dsg_x;
    logic             dsg_y;
    ctx_t             ctx;
  } s3_t;

  typedef struct packed {
    logic [PROD_W-1:0] ph_x;
    logic [PROD_W-1:0] pl_x;
    logic [PROD_W-1:0] ph_y;
    logic [PROD_W-1:0] pl_y;
    logic [N2_W-1:0]   n2;
    logic              sx;
    logic              sy;
    logic              coin;
    ctx_t              ctx;
  } s4_t;

  typedef struct packed {
    logic [R1_W-1:0] rem_x;
    logic [R1_W-1:0] rem_y;
    logic [Q1_W-1:0] low_x;
    logic [Q1_W-1:0] low_y;
    logic [Q1_W-1:0] q_x;
    logic [Q1_W-1:0] q_y;
    logic [N2_W-1:0] n2;
    logic            sx;
    logic            sy;
    logic            coin;
    ctx_t            ctx;
  } div1_t;

  typedef struct packed {
    logic [R2_W-1:0]   rem_ax;
    logic [R2_W-1:0]   rem_ay;
    logic [R2_W-1:0]   rem_bx;
    logic [R2_W-1:0]   rem_by;
    logic [Q2_W-1:0]   low_ax;
    logic [Q2_W-1:0]   low_ay;
    logic [Q2_W-1:0]   low_bx;
    logic [Q2_W-1:0]   low_by;
    logic [Q2_W-1:0]   q_ax;
    logic [Q2_W-1:0]   q_ay;
    logic [Q2_W-1:0]   q_bx;
    logic [Q2_W-1:0]   q_by;
    logic [MSUM_W-1:0] msum;
    logic              sx;
    logic              sy;
    logic              coin;
    logic              skip;
    ctx_t              ctx;
  } div2_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] a_x;
    logic signed [VEL_W-1:0] a_y;
    logic signed [VEL_W-1:0] b_x;
    logic signed [VEL_W-1:0] b_y;
    logic                    coin;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/elastic_pair_collision_2d.sv =====
`default_nettype none

// Channel | Handshake          | Word
// --------+--------------------+----------------------------------------------
// in      | in_valid, in_stall | positions, velocities, masses of a pair
// out     | out_valid,out_stall| both new velocities and the coincident flag
//
// One word enters per cycle while the skid register is empty, and one result
// leaves per cycle while out_stall is low. Each bit-per-stage divider follows
// its load stage (33 stages for the projection, 34 for the mass weighting).
// Reset clears only the valid bits; payload registers are not reset.
// A stalled result is held in the output register and the next one in a skid
// register; in_stall is that skid register's valid bit, so input accepts
// while a single finished result waits.

module elastic_pair_collision_2d (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   a_pos_x,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   a_pos_y,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   a_vel_x,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   a_vel_y,
  input  wire logic        [epc2d_pkg::MASS_W-1:0]  a_mass,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   b_pos_x,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   b_pos_y,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   b_vel_x,
  input  wire logic signed [epc2d_pkg::VEL_W-1:0]   b_vel_y,
  input  wire logic        [epc2d_pkg::MASS_W-1:0]  b_mass,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [epc2d_pkg::VEL_W-1:0]   a_new_vel_x,
  output logic signed      [epc2d_pkg::VEL_W-1:0]   a_new_vel_y,
  output logic signed      [epc2d_pkg::VEL_W-1:0]   b_new_vel_x,
  output logic signed      [epc2d_pkg::VEL_W-1:0]   b_new_vel_y,
  output logic                                      coincident
);

  import epc2d_pkg::*;

  // Four front stages, then both divider chains including their load stage.
  localparam int NST = 4 + (Q1_W + 1) + (Q2_W + 1);

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  // Returns the new remainder above the quotient bit.
  function automatic logic [R1_W:0] step1(input logic [R1_W-1:0] rem, input logic bin,
                                          input logic [R1_W-1:0] den);
    logic [R1_W:0] sh;
    logic          ge;
    sh = {rem, bin};
    ge = (sh >= {1'b0, den});
    step1 = {(ge ? R1_W'(sh - {1'b0, den}) : sh[R1_W-1:0]), ge};
  endfunction

  function automatic logic [R2_W:0] step2(input logic [R2_W-1:0] rem, input logic bin,
                                          input logic [R2_W-1:0] den);
    logic [R2_W:0] sh;
    logic          ge;
    sh = {rem, bin};
    ge = (sh >= {1'b0, den});
    step2 = {(ge ? R2_W'(sh - {1'b0, den}) : sh[R2_W-1:0]), ge};
  endfunction

  function automatic logic signed [COR_W-1:0] signed_cor(input logic [Q2_W-1:0] q,
                                                         input logic neg, input logic skip);
    logic signed [COR_W-1:0] m;
    m = signed'({{(COR_W - Q2_W){1'b0}}, q});
    if (skip) begin
      signed_cor = '0;
    end else begin
      signed_cor = neg ? -m : m;
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] sat(input logic signed [COR_W-1:0] x);
    logic [COR_W-VEL_W:0] top;
    top = x[COR_W-1:VEL_W-1];
    if ((&top) || !(|top)) begin
      sat = x[VEL_W-1:0];
    end else if (x[COR_W-1]) begin
      sat = {1'b1, {(VEL_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(VEL_W - 1){1'b1}}};
    end
  endfunction

  // The whole pipeline moves together while the skid register is empty.
  logic             en;
  logic             in_acc;
  logic [NST-1:0]   vld;
  s1_t              s1;
  s2_t              s2;
  s3_t              s3;
  s4_t              s4;
  div1_t            d1 [0:Q1_W];
  div2_t            d2 [0:Q2_W];
  res_t             res;
  res_t             out_word;
  res_t             skid;
  logic             skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_acc};
    end
  end

  // Stage 1: differences of positions and velocities.
  always_ff @(posedge clk) begin
    if (en) begin
      s1.dx       <= {a_pos_x[VEL_W-1], a_pos_x} - {b_pos_x[VEL_W-1], b_pos_x};
      s1.dy       <= {a_pos_y[VEL_W-1], a_pos_y} - {b_pos_y[VEL_W-1], b_pos_y};
      s1.dvx      <= {a_vel_x[VEL_W-1], a_vel_x} - {b_vel_x[VEL_W-1], b_vel_x};
      s1.dvy      <= {a_vel_y[VEL_W-1], a_vel_y} - {b_vel_y[VEL_W-1], b_vel_y};
      s1.ctx.va_x <= a_vel_x;
      s1.ctx.va_y <= a_vel_y;
      s1.ctx.vb_x <= b_vel_x;
      s1.ctx.vb_y <= b_vel_y;
      s1.ctx.ma   <= a_mass;
      s1.ctx.mb   <= b_mass;
    end
  end

  // Stage 2: the four 33 x 33 products of the dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      s2.pix    <= s1.dvx * s1.dx;
      s2.piy    <= s1.dvy * s1.dy;
      s2.pnx    <= s1.dx * s1.dx;
      s2.pny    <= s1.dy * s1.dy;
      s2.dmag_x <= s1.dx[DIFF_W-1] ? MAG_W'(-s1.dx) : MAG_W'(s1.dx);
      s2.dmag_y <= s1.dy[DIFF_W-1] ? MAG_W'(-s1.dy) : MAG_W'(s1.dy);
      s2.dsg_x  <= s1.dx[DIFF_W-1];
      s2.dsg_y  <= s1.dy[DIFF_W-1];
      s2.ctx    <= s1.ctx;
    end
  end

  // Stage 3: sums give the relative speed along d and |d|^2.
  logic signed [INNER_W-1:0] inner;
  assign inner = INNER_W'(s2.pix) + INNER_W'(s2.piy);

  always_ff @(posedge clk) begin
    if (en) begin
      s3.imag   <= inner[INNER_W-1] ? N2_W'(-inner) : N2_W'(inner);
      s3.isg    <= inner[INNER_W-1];
      s3.n2     <= N2_W'(unsigned'(s2.pnx)) + N2_W'(unsigned'(s2.pny));
      s3.dmag_x <= s2.dmag_x;
      s3.dmag_y <= s2.dmag_y;
      s3.dsg_x  <= s2.dsg_x;
      s3.dsg_y  <= s2.dsg_y;
      s3.ctx    <= s2.ctx;
    end
  end

  // Stage 4: the wide numerator inner * d is built from two halves per axis.
  always_ff @(posedge clk) begin
    if (en) begin
      s4.ph_x <= s3.imag[N2_W-1:HALF_W] * s3.dmag_x;
      s4.pl_x <= s3.imag[HALF_W-1:0] * s3.dmag_x;
      s4.ph_y <= s3.imag[N2_W-1:HALF_W] * s3.dmag_y;
      s4.pl_y <= s3.imag[HALF_W-1:0] * s3.dmag_y;
      s4.n2   <= s3.n2;
      s4.sx   <= s3.isg ^ s3.dsg_x;
      s4.sy   <= s3.isg ^ s3.dsg_y;
      s4.coin <= (s3.n2 == '0);
      s4.ctx  <= s3.ctx;
    end
  end

  // Divider load: the numerator's top part is already below |d|^2.
  logic [NUM1_W-1:0] num_x;
  logic [NUM1_W-1:0] num_y;
  assign num_x = {s4.ph_x, {HALF_W{1'b0}}} + NUM1_W'(s4.pl_x);
  assign num_y = {s4.ph_y, {HALF_W{1'b0}}} + NUM1_W'(s4.pl_y);

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0].rem_x <= num_x[NUM1_W-1:Q1_W];
      d1[0].rem_y <= num_y[NUM1_W-1:Q1_W];
      d1[0].low_x <= num_x[Q1_W-1:0];
      d1[0].low_y <= num_y[Q1_W-1:0];
      d1[0].q_x   <= '0;
      d1[0].q_y   <= '0;
      d1[0].n2    <= s4.n2;
      d1[0].sx    <= s4.sx;
      d1[0].sy    <= s4.sy;
      d1[0].coin  <= s4.coin;
      d1[0].ctx   <= s4.ctx;
    end
  end

  // Projection divider: one quotient bit per stage for both axes.
  for (genvar k = 0; k < Q1_W; k++) begin : g_div1
    logic [R1_W:0] nx;
    logic [R1_W:0] ny;
    div1_t         nxt;
    assign nx = step1(d1[k].rem_x, d1[k].low_x[Q1_W-1], d1[k].n2);
    assign ny = step1(d1[k].rem_y, d1[k].low_y[Q1_W-1], d1[k].n2);
    always_comb begin
      nxt       = d1[k];
      nxt.rem_x = nx[R1_W:1];
      nxt.rem_y = ny[R1_W:1];
      nxt.low_x = {d1[k].low_x[Q1_W-2:0], 1'b0};
      nxt.low_y = {d1[k].low_y[Q1_W-2:0], 1'b0};
      nxt.q_x   = {d1[k].q_x[Q1_W-2:0], nx[0]};
      nxt.q_y   = {d1[k].q_y[Q1_W-2:0], ny[0]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1[k+1] <= nxt;
      end
    end
  end

  // Mass weighting: 2*mb*g and 2*ma*g, loaded straight into the second divider.
  div1_t             dq;
  logic [K_W-1:0]    ka;
  logic [K_W-1:0]    kb;
  logic [MSUM_W-1:0] msum;
  logic [NUM2_W-1:0] pr_ax;
  logic [NUM2_W-1:0] pr_ay;
  logic [NUM2_W-1:0] pr_bx;
  logic [NUM2_W-1:0] pr_by;

  assign dq    = d1[Q1_W];
  assign ka    = {dq.ctx.mb, 1'b0};
  assign kb    = {dq.ctx.ma, 1'b0};
  assign msum  = {1'b0, dq.ctx.ma} + {1'b0, dq.ctx.mb};
  assign pr_ax = ka * dq.q_x;
  assign pr_ay = ka * dq.q_y;
  assign pr_bx = kb * dq.q_x;
  assign pr_by = kb * dq.q_y;

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0].rem_ax <= {1'b0, pr_ax[NUM2_W-1:Q2_W]};
      d2[0].rem_ay <= {1'b0, pr_ay[NUM2_W-1:Q2_W]};
      d2[0].rem_bx <= {1'b0, pr_bx[NUM2_W-1:Q2_W]};
      d2[0].rem_by <= {1'b0, pr_by[NUM2_W-1:Q2_W]};
      d2[0].low_ax <= pr_ax[Q2_W-1:0];
      d2[0].low_ay <= pr_ay[Q2_W-1:0];
      d2[0].low_bx <= pr_bx[Q2_W-1:0];
      d2[0].low_by <= pr_by[Q2_W-1:0];
      d2[0].q_ax   <= '0;
      d2[0].q_ay   <= '0;
      d2[0].q_bx   <= '0;
      d2[0].q_by   <= '0;
      d2[0].msum   <= msum;
      d2[0].sx     <= dq.sx;
      d2[0].sy     <= dq.sy;
      d2[0].coin   <= dq.coin;
      // With coincident positions or a zero mass sum the velocities pass through.
      d2[0].skip   <= dq.coin || (msum == '0);
      d2[0].ctx    <= dq.ctx;
    end
  end

  // Mass divider: four lanes sharing the divisor ma + mb.
  for (genvar k = 0; k < Q2_W; k++) begin : g_div2
    logic [R2_W:0] nax;
    logic [R2_W:0] nay;
    logic [R2_W:0] nbx;
    logic [R2_W:0] nby;
    div2_t         nxt;
    assign nax = step2(d2[k].rem_ax, d2[k].low_ax[Q2_W-1], d2[k].msum);
    assign nay = step2(d2[k].rem_ay, d2[k].low_ay[Q2_W-1], d2[k].msum);
    assign nbx = step2(d2[k].rem_bx, d2[k].low_bx[Q2_W-1], d2[k].msum);
    assign nby = step2(d2[k].rem_by, d2[k].low_by[Q2_W-1], d2[k].msum);
    always_comb begin
      nxt        = d2[k];
      nxt.rem_ax = nax[R2_W:1];
      nxt.rem_ay = nay[R2_W:1];
      nxt.rem_bx = nbx[R2_W:1];
      nxt.rem_by = nby[R2_W:1];
      nxt.low_ax = {d2[k].low_ax[Q2_W-2:0], 1'b0};
      nxt.low_ay = {d2[k].low_ay[Q2_W-2:0], 1'b0};
      nxt.low_bx = {d2[k].low_bx[Q2_W-2:0], 1'b0};
      nxt.low_by = {d2[k].low_by[Q2_W-2:0], 1'b0};
      nxt.q_ax   = {d2[k].q_ax[Q2_W-2:0], nax[0]};
      nxt.q_ay   = {d2[k].q_ay[Q2_W-2:0], nay[0]};
      nxt.q_bx   = {d2[k].q_bx[Q2_W-2:0], nbx[0]};
      nxt.q_by   = {d2[k].q_by[Q2_W-2:0], nby[0]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2[k+1] <= nxt;
      end
    end
  end

  // Apply the corrections with their sign and clamp to 32 bits.
  div2_t                   df;
  logic signed [COR_W-1:0] c_ax;
  logic signed [COR_W-1:0] c_ay;
  logic signed [COR_W-1:0] c_bx;
  logic signed [COR_W-1:0] c_by;

  assign df   = d2[Q2_W];
  assign c_ax = signed_cor(df.q_ax, df.sx, df.skip);
  assign c_ay = signed_cor(df.q_ay, df.sy, df.skip);
  assign c_bx = signed_cor(df.q_bx, df.sx, df.skip);
  assign c_by = signed_cor(df.q_by, df.sy, df.skip);

  always_comb begin
    res.a_x  = sat(COR_W'(df.ctx.va_x) - c_ax);
    res.a_y  = sat(COR_W'(df.ctx.va_y) - c_ay);
    res.b_x  = sat(COR_W'(df.ctx.vb_x) + c_bx);
    res.b_y  = sat(COR_W'(df.ctx.vb_y) + c_by);
    res.coin = df.coin;
  end

  // Output register with a one-word skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_word   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      if (vld[NST-1]) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= vld[NST-1];
      if (vld[NST-1]) begin
        out_word <= res;
      end
    end
  end

  assign a_new_vel_x = out_word.a_x;
  assign a_new_vel_y = out_word.a_y;
  assign b_new_vel_x = out_word.b_x;
  assign b_new_vel_y = out_word.b_y;
  assign coincident  = out_word.coin;

endmodule

`default_nettype wire
